// ===== sv/pmp_pkg.sv =====
// Package for the position motion profile generator.
// Holds shared constants, codes, the iterative unit request type and saturation helpers.
// No dependencies.
package pmp_pkg;

  localparam int ValueWidth    = 32;
  localparam int FractionBits  = 16;
  localparam int StepFracBits  = 24;
  localparam int MulWidth      = 33;
  localparam int ProdWidth     = 2 * MulWidth;
  localparam int IterSteps     = 32;
  localparam int DefaultTolInt = ((1 << FractionBits) + 500) / 1000;
  localparam int MinStepInt    = (1 << StepFracBits) / 1000000 + 1;

  localparam logic [32:0] DefaultTol  = 33'(DefaultTolInt);
  localparam logic [23:0] MinTimeStep = 24'(MinStepInt);

  typedef enum logic [1:0] {
    OpTick   = 2'd0,
    OpTarget = 2'd1,
    OpReset  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CfgMode  = 3'd0,
    CfgRate  = 3'd1,
    CfgAccel = 3'd2,
    CfgJerk  = 3'd3,
    CfgTol   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ModePass   = 2'd0,
    ModeTrap   = 2'd1,
    ModeScurve = 2'd2
  } mode_e;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } iter_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    logic signed [31:0] r;
    if (x > 36'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [32:0] mag32(input logic signed [31:0] x);
    logic signed [32:0] w;
    w = {x[31], x};
    return x[31] ? 33'(-w) : 33'(w);
  endfunction

  // Clamp a difference to plus or minus the allowed step.
  function automatic logic signed [34:0] slew(input logic signed [34:0] diff,
                                               input logic [31:0] step);
    logic [34:0] m;
    logic signed [34:0] s;
    m = diff[34] ? 35'(-diff) : 35'(diff);
    s = $signed({3'b000, step});
    if (m > {3'b000, step}) begin
      return diff[34] ? -s : s;
    end
    return diff;
  endfunction

endpackage

// ===== sv/pmp_mul.sv =====
// Shared 33 by 33 bit unsigned multiplier with a registered product.
// Depends on pmp_pkg.
module pmp_mul (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [pmp_pkg::MulWidth-1:0]   a_i,
  input  logic [pmp_pkg::MulWidth-1:0]   b_i,
  output logic [pmp_pkg::ProdWidth-1:0]  p_o
);
  import pmp_pkg::*;

  logic [ProdWidth-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= ProdWidth'(a_i) * ProdWidth'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

// ===== sv/pmp_iter.sv =====
// Shared restoring unit: square root of a 64-bit value or 57-by-24 bit division.
// One result bit per cycle, 32 result bits in all. Depends on pmp_pkg.
module pmp_iter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pmp_pkg::iter_req_t  req_i,
  input  logic [63:0]         radicand_i,
  input  logic [23:0]         divisor_i,
  output logic                done_o,
  output logic [31:0]         result_o
);
  import pmp_pkg::*;

  logic        busy_q, done_q, sqrt_q;
  logic [4:0]  cnt_q;
  logic [34:0] rem_q, rem_sh, trial, rem_nx;
  logic [63:0] work_q;
  logic [31:0] res_q;
  logic [23:0] div_q;
  logic        ge;

  always_comb begin
    rem_sh = sqrt_q ? {rem_q[32:0], work_q[63:62]} : {rem_q[33:0], work_q[63]};
    trial  = sqrt_q ? {1'b0, res_q, 2'b01} : {11'b0, div_q};
    ge     = rem_sh >= trial;
    rem_nx = ge ? rem_sh - trial : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(IterSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sqrt_q <= req_i.is_sqrt;
      rem_q  <= req_i.is_sqrt ? '0 : {10'b0, radicand_i[56:32]};
      work_q <= req_i.is_sqrt ? radicand_i : {radicand_i[31:0], 32'b0};
      res_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_nx;
      res_q  <= {res_q[30:0], ge};
      work_q <= sqrt_q ? {work_q[61:0], 2'b00} : {work_q[62:0], 1'b0};
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== sv/position_motion_profile.sv =====
// Position motion profile generator: sequencer, state and limits around one shared
// multiplier and one shared square root / divide unit.
// Set-target and reset transactions are accepted in idle and leave the sequencer idle.
// A tick holds the input through the sequencer states, also while the square root or
// division runs; passthrough skips the computation states. The result is registered,
// and a stalled result holds the sequencer. One tick is in work at a time.
// Reset (asynchronous, active low) sets the sequencer to idle and clears limits, axis
// state and output valid to zero; datapath and output payload registers are not reset.
module position_motion_profile (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] position_value_i,
  input  logic [23:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] planned_position_o,
  output logic signed [31:0] planned_rate_o,
  output logic signed [31:0] planned_accel_o,
  output logic               arrived_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import pmp_pkg::*;

  typedef enum logic [18:0] {
    SIdle = 19'h00001, SPass = 19'h00002, SErr  = 19'h00004, SMb   = 19'h00008,
    SMr   = 19'h00010, SBr   = 19'h00020, SSq   = 19'h00040, STgt  = 19'h00080,
    STr   = 19'h00100, STr2  = 19'h00200, SSa   = 19'h00400, SSn   = 19'h00800,
    SDv   = 19'h01000, SSj   = 19'h02000, SSj2  = 19'h04000, SSv   = 19'h08000,
    SSv2  = 19'h10000, SPos  = 19'h20000, SPos2 = 19'h40000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]  mode_q;
  logic [30:0] rate_lim_q, accel_lim_q, jerk_lim_q, tol_q;
  logic signed [31:0] goal_q, pos_q, rate_q, acc_q;
  logic        moving_q;
  logic [23:0] t_q;
  logic signed [32:0] err_q;
  logic [31:0] rlim_q;
  logic signed [33:0] e_q;
  logic signed [32:0] tacc_q;
  logic [65:0] nb_q;

  logic out_valid_q, arrived_q;
  logic signed [31:0] out_pos_q, out_rate_q, out_acc_q;

  logic                 mul_en;
  logic [MulWidth-1:0]  mul_a, mul_b;
  logic [ProdWidth-1:0] prod;
  iter_req_t            iter_req;
  logic [63:0]          iter_rad;
  logic                 iter_done;
  logic [31:0]          iter_res;

  logic        accept, out_free;
  logic [32:0] err_mag, rmag, amag, tol, move_mag;
  logic signed [32:0] move_diff;
  logic [33:0] emag;
  logic [56:0] num;
  logic [32:0] scaled;
  logic signed [33:0] scaled_s;
  logic [31:0] step;
  logic signed [33:0] tgt;
  logic [30:0] qa;

  pmp_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  pmp_iter u_iter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (iter_req),
    .radicand_i (iter_rad),
    .divisor_i  (t_q),
    .done_o     (iter_done),
    .result_o   (iter_res)
  );

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != SIdle);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    err_mag   = err_q[32] ? 33'(-err_q) : 33'(err_q);
    rmag      = mag32(rate_q);
    amag      = mag32(acc_q);
    tol       = (tol_q != '0) ? {2'b00, tol_q} : DefaultTol;
    emag      = e_q[33] ? 34'(-e_q) : 34'(e_q);
    num       = {emag[32:0], 24'b0};
    scaled    = prod[56:24];
    step      = prod[55:24];
    // The scaled product takes the sign of the acceleration or of the rate.
    scaled_s  = ((state_q == SSv2) ? acc_q[31] : rate_q[31]) ? -$signed({1'b0, scaled})
                                                              : $signed({1'b0, scaled});
    move_diff = {position_value_i[31], position_value_i} - {pos_q[31], pos_q};
    move_mag  = move_diff[32] ? 33'(-move_diff) : 33'(move_diff);
    tgt       = '0;
    if (!err_q[32] && err_q != '0) begin
      tgt = $signed({2'b00, rlim_q});
    end else if (err_q[32]) begin
      tgt = -$signed({2'b00, rlim_q});
    end
    qa = (iter_res < {1'b0, accel_lim_q}) ? iter_res[30:0] : accel_lim_q;
  end

  // Operand selection for the shared multiplier and requests to the square root / divide unit.
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    iter_req = '0;
    iter_rad = nb_q[63:0];
    unique case (state_q)
      SMb: begin
        mul_a = {1'b0, accel_lim_q, 1'b0};
        mul_b = err_mag;
      end
      SMr: begin
        mul_a = rmag;
        mul_b = rmag;
      end
      STr, SSa: begin
        mul_a = {2'b00, accel_lim_q};
        mul_b = {9'b0, t_q};
      end
      SSj: begin
        mul_a = {2'b00, jerk_lim_q};
        mul_b = {9'b0, t_q};
      end
      SSv: begin
        mul_a = amag;
        mul_b = {9'b0, t_q};
      end
      SPos: begin
        mul_a = rmag;
        mul_b = {9'b0, t_q};
      end
      default: mul_en = 1'b0;
    endcase
    if (state_q == SBr) begin
      iter_req.is_sqrt = 1'b1;
      iter_req.start   = (accel_lim_q != '0) ? (nb_q <= prod) : (err_mag == '0);
    end else if (state_q == SSn) begin
      iter_rad         = {7'b0, num};
      iter_req.start   = !(prod <= {9'b0, num});
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (accept && op_e'(operation_i) == OpTick) begin
          state_d = (mode_q == ModePass) ? SPass : SErr;
        end
      end
      SPass:  if (out_free) state_d = SIdle;
      SErr:   state_d = SMb;
      SMb:    state_d = SMr;
      SMr:    state_d = SBr;
      SBr:    state_d = iter_req.start ? SSq : STgt;
      SSq:    if (iter_done) state_d = STgt;
      STgt: begin
        if (mode_q == ModeTrap) begin
          state_d = STr;
        end else if (t_q >= MinTimeStep) begin
          state_d = SSa;
        end else begin
          state_d = SSj;
        end
      end
      STr:    state_d = STr2;
      STr2:   state_d = SPos;
      SSa:    state_d = SSn;
      SSn:    state_d = iter_req.start ? SDv : SSj;
      SDv:    if (iter_done) state_d = SSj;
      SSj:    state_d = SSj2;
      SSj2:   state_d = SSv;
      SSv:    state_d = SSv2;
      SSv2:   state_d = SPos;
      SPos:   state_d = SPos2;
      SPos2:  if (out_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      mode_q      <= '0;
      rate_lim_q  <= '0;
      accel_lim_q <= '0;
      jerk_lim_q  <= '0;
      tol_q       <= '0;
      goal_q      <= '0;
      pos_q       <= '0;
      rate_q      <= '0;
      acc_q       <= '0;
      moving_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgMode:  mode_q      <= cfg_data_i[1:0];
          CfgRate:  rate_lim_q  <= cfg_data_i[30:0];
          CfgAccel: accel_lim_q <= cfg_data_i[30:0];
          CfgJerk:  jerk_lim_q  <= cfg_data_i[30:0];
          CfgTol:   tol_q       <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if ((state_q == SPass || state_q == SPos2) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        unique case (operation_i)
          OpTarget: begin
            goal_q   <= position_value_i;
            moving_q <= move_mag > DefaultTol;
          end
          OpReset: begin
            goal_q   <= position_value_i;
            pos_q    <= position_value_i;
            rate_q   <= '0;
            acc_q    <= '0;
            moving_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state_q == STr2) begin
        rate_q <= sat32(36'(rate_q) + 36'(slew(35'(e_q), step)));
      end
      if (state_q == SSj2) begin
        acc_q <= sat32(36'(acc_q) + 36'(slew(35'(tacc_q) - 35'(acc_q), step)));
      end
      if (state_q == SSv2) begin
        rate_q <= sat32(36'(rate_q) + 36'(scaled_s));
      end
      if (state_q == SPos2 && out_free) begin
        if (err_mag <= tol && rmag <= tol) begin
          pos_q    <= goal_q;
          rate_q   <= '0;
          acc_q    <= '0;
          moving_q <= 1'b0;
        end else begin
          pos_q    <= sat32(36'(pos_q) + 36'(scaled_s));
          moving_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers of the tick in progress and the output transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      t_q <= time_step_i;
    end
    if (state_q == SErr) begin
      err_q <= {goal_q[31], goal_q} - {pos_q[31], pos_q};
    end
    if (state_q == SMr) begin
      nb_q <= prod;
    end
    if (state_q == SBr) begin
      rlim_q <= {1'b0, rate_lim_q};
    end
    if (state_q == SSq && iter_done) begin
      rlim_q <= iter_res;
    end
    if (state_q == STgt) begin
      e_q    <= tgt - {{2{rate_q[31]}}, rate_q};
      tacc_q <= '0;
    end
    if (state_q == SSn && !iter_req.start) begin
      tacc_q <= e_q[33] ? -$signed({2'b00, accel_lim_q}) : $signed({2'b00, accel_lim_q});
    end
    if (state_q == SDv && iter_done) begin
      tacc_q <= e_q[33] ? -$signed({2'b00, qa}) : $signed({2'b00, qa});
    end
    if (state_q == SPass && out_free) begin
      out_pos_q  <= goal_q;
      out_rate_q <= '0;
      out_acc_q  <= '0;
      arrived_q  <= 1'b1;
    end
    if (state_q == SPos2 && out_free) begin
      out_pos_q  <= sat32(36'(pos_q) + 36'(scaled_s));
      out_rate_q <= rate_q;
      out_acc_q  <= acc_q;
      arrived_q  <= (err_mag <= tol) && (rmag <= tol);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign planned_position_o = out_pos_q;
  assign planned_rate_o     = out_rate_q;
  assign planned_accel_o    = out_acc_q;
  assign arrived_o          = arrived_q;

endmodule

// ===== sv/pmp_checker.sv =====
// Port-level checker for the position motion profile generator, bound to the top level.
// Depends on pmp_pkg and position_motion_profile.
module pmp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         operation_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] planned_position_o
);
  import pmp_pkg::*;

  // A tick transaction always keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && operation_i == OpTick) |=> in_stall_o)
    else $error("tick accepted but block ready next cycle");

  // A result only appears while a tick is being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a tick in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(planned_position_o))
    else $error("stalled result changed");

endmodule

bind position_motion_profile pmp_checker u_pmp_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .operation_i        (operation_i),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .planned_position_o (planned_position_o)
);

// ===== tb/tb.sv =====
// Self-checking testbench for position_motion_profile: directed stimulus table, then
// random reset, target and tick sequences under several register settings.
// Depends on pmp_pkg and the position_motion_profile RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pmp_pkg::*;

  localparam longint VMax = 64'sd2147483647;
  localparam longint VMin = -64'sd2147483648;
  localparam logic [30:0] Lim = 31'h7FFFFFFF;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] rate;
    logic signed [31:0] accel;
    logic               arr;
  } plan_t;

  typedef struct {
    int          setting;
    logic [1:0]  op;
    logic [31:0] pos;
    logic [23:0] dt;
    bit          typed;
    plan_t       want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] operation_i = '0;
  logic signed [31:0] position_value_i = '0;
  logic [23:0] time_step_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] planned_position_o, planned_rate_o, planned_accel_o;
  logic arrived_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  position_motion_profile dut (.*);

  always #1 clk_i = ~clk_i;

  // Shadow registers and axis state of the predictor.
  logic [1:0]  prof_mode;
  logic [30:0] rate_max, accel_max, jerk_max, tol_cfg;
  longint goal_pos, cur_pos, cur_rate, cur_accel;

  plan_t plan_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_cnt = 0;
  bit calm = 1'b0;

  function automatic longint sat_v(longint x);
    return x > VMax ? VMax : (x < VMin ? VMin : x);
  endfunction

  function automatic longint unsigned mag_v(longint x);
    return x < 0 ? -x : x;
  endfunction

  // (a*b) >> 24 with truncation, capped.
  function automatic longint unsigned mul_dt(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = (128'(a) * 128'(b)) >> StepFracBits;
    return p > (128'd1 << 60) ? (64'd1 << 60) : p[63:0];
  endfunction

  function automatic longint scale_dt(longint v, longint unsigned t);
    longint p;
    p = longint'(mul_dt(mag_v(v), t));
    return v < 0 ? -p : p;
  endfunction

  function automatic longint clamp_step(longint diff, longint unsigned step);
    if (mag_v(diff) > step) return diff < 0 ? -longint'(step) : longint'(step);
    return diff;
  endfunction

  // Largest q below 2^50 with q*m <= n, or q*q <= n when m is zero.
  function automatic longint unsigned floor_div_sqrt(logic [127:0] n, longint unsigned m);
    longint unsigned q, c;
    q = 0;
    for (int b = 49; b >= 0; b--) begin
      c = q | (64'd1 << b);
      if (128'(c) * 128'(m != 0 ? m : c) <= n) q = c;
    end
    return q;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    return 32'(sat_v(v));
  endfunction

  task automatic predict_item(input logic [1:0] op, input logic [31:0] raw,
                              input logic [23:0] dt, output bit got, output plan_t p);
    longint pos, err, rlim, tgt, e, tgt_acc;
    longint unsigned err_mag, a, r, t, q, tol;
    logic [127:0] n;
    bit brake;
    pos = longint'($signed(raw));
    t = dt;
    got = 1'b0;
    p = '{default: '0};
    if (op == OpTarget) begin
      goal_pos = pos;
    end else if (op == OpReset) begin
      goal_pos = pos;
      cur_pos = pos;
      cur_rate = 0;
      cur_accel = 0;
    end else if (op == OpTick) begin
      got = 1'b1;
      if (prof_mode == ModePass) begin
        p = '{clip32(goal_pos), 0, 0, 1'b1};
      end else begin
        err = goal_pos - cur_pos;
        err_mag = mag_v(err);
        a = accel_max;
        r = mag_v(cur_rate);
        brake = a != 0 ? (128'(2 * a) * 128'(err_mag) <= 128'(r) * 128'(r))
                       : (err_mag == 0);
        rlim = brake ? longint'(floor_div_sqrt(128'(2 * a) * 128'(err_mag), 0))
                     : longint'(rate_max);
        tgt = err > 0 ? rlim : (err < 0 ? -rlim : 0);
        if (prof_mode == ModeTrap) begin
          cur_rate = sat_v(cur_rate + clamp_step(tgt - cur_rate, mul_dt(a, t)));
        end else begin
          e = tgt - cur_rate;
          tgt_acc = 0;
          // Below about a microsecond the target acceleration is forced to zero.
          if (t * 1000000 > (64'd1 << StepFracBits)) begin
            n = 128'(mag_v(e)) << StepFracBits;
            q = (128'(a) * 128'(t) <= n) ? a : floor_div_sqrt(n, t);
            if (q > a) q = a;
            tgt_acc = e < 0 ? -longint'(q) : longint'(q);
          end
          cur_accel = sat_v(cur_accel + clamp_step(tgt_acc - cur_accel,
                                                   mul_dt(jerk_max, t)));
          cur_rate = sat_v(cur_rate + scale_dt(cur_accel, t));
        end
        cur_pos = sat_v(cur_pos + scale_dt(cur_rate, t));
        p.pos = clip32(cur_pos);
        p.rate = clip32(cur_rate);
        p.accel = clip32(cur_accel);
        tol = tol_cfg != 0 ? tol_cfg : DefaultTolInt;
        p.arr = err_mag <= tol && mag_v(cur_rate) <= tol;
        if (p.arr) begin
          cur_pos = goal_pos;
          cur_rate = 0;
          cur_accel = 0;
        end
      end
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    plan_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (plan_q.size() == 0) begin
        report("unexpected result", planned_position_o, 0);
      end else begin
        w = plan_q.pop_front();
        if (planned_position_o !== w.pos) report("position", planned_position_o, w.pos);
        if (planned_rate_o !== w.rate) report("rate", planned_rate_o, w.rate);
        if (planned_accel_o !== w.accel) report("accel", planned_accel_o, w.accel);
        if (arrived_o !== w.arr) report("arrived", arrived_o, w.arr);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      out_stall_i = 1'b1;
      hold_cnt--;
    end else begin
      out_stall_i = !calm && ($urandom_range(99) < 8);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("position_motion_profile test failed");
      $finish;
    end
  end

  task automatic wait_idle();
    wait (plan_q.size() == 0);
    // A set-target may still be in flight, so wait out a margin before returning.
    repeat (120) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgMode:  prof_mode = data[1:0];
      CfgRate:  rate_max = data[30:0];
      CfgAccel: accel_max = data[30:0];
      CfgJerk:  jerk_max = data[30:0];
      CfgTol:   tol_cfg = data[30:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic configure(input logic [31:0] m, r, a, j, tl);
    wait_idle();
    write_reg(CfgMode, m);
    write_reg(CfgRate, r);
    write_reg(CfgAccel, a);
    write_reg(CfgJerk, j);
    write_reg(CfgTol, tl);
  endtask

  // Offers one transaction from a falling edge and returns at the falling edge after
  // acceptance, with valid still high.
  task automatic send(input logic [1:0] op, input logic [31:0] pos, input logic [23:0] dt,
                      input bit typed, input plan_t want);
    bit got;
    plan_t p;
    if (!calm) begin
      while ($urandom_range(99) < 8) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i = 1'b1;
    operation_i = op;
    position_value_i = pos;
    time_step_i = dt;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(op, pos, dt, got, p);
    if (got) plan_q.push_back(typed ? want : p);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(4))
      0: return 0;
      1: return 32'h7FFFFFFF | ($urandom_range(1) << 31);
      2: return $urandom_range(32'h0001_0000, 32'h0100_0000);
      3: return $urandom_range(32'h0000_1000, 32'h0020_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] pick_dt();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(20);
      default: return $urandom_range(2000, 400000);
    endcase
  endfunction

  // Directed settings: reset values, trapezoid, S-curve without acceleration limit,
  // and the unused mode value with every limit at its top.
  logic [31:0] dir_set[4][5] = '{
    '{0, 0, 0, 0, 0},
    '{ModeTrap, 32'h000A_0000, 32'h0014_0000, 0, 0},
    '{ModeScurve, 32'h0005_0000, 0, 32'hFFFF_FFFF, 32'h0000_0100},
    '{3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}
  };

  row_t dir_rows[] = '{
    '{0, OpTick,   32'h0,          24'h0,      1, '{32'sh0, 0, 0, 1}},
    '{0, OpTarget, 32'h7FFF_FFFF,  24'h0,      0, '{0, 0, 0, 0}},
    '{0, OpTick,   32'h0,          24'hFFFFFF, 1, '{32'sh7FFF_FFFF, 0, 0, 1}},
    '{0, OpTarget, 32'h8000_0000,  24'h0,      0, '{0, 0, 0, 0}},
    '{0, OpTick,   32'hFFFF_FFFF,  24'h1,      1, '{32'sh8000_0000, 0, 0, 1}},
    '{0, OpReset,  32'h0000_3039,  24'h0,      0, '{0, 0, 0, 0}},
    '{0, 2'd3,     32'h1234_5678,  24'h5A5A5A, 0, '{0, 0, 0, 0}},
    '{0, OpTick,   32'h0,          24'h0,      1, '{32'sh3039, 0, 0, 1}},
    '{1, OpReset,  32'h0,          24'h0,      0, '{0, 0, 0, 0}},
    '{1, OpTarget, 32'h0003_0000,  24'h0,      0, '{0, 0, 0, 0}},
    '{1, OpTick,   32'h0,          24'h0,      0, '{0, 0, 0, 0}},
    '{1, OpTick,   32'h0,          24'h19_999A, 0, '{0, 0, 0, 0}},
    '{1, OpTick,   32'h0,          24'h19_999A, 0, '{0, 0, 0, 0}},
    '{1, OpTick,   32'h0,          24'hFFFFFF, 0, '{0, 0, 0, 0}},
    '{1, OpTick,   32'h0,          24'hFFFFFF, 0, '{0, 0, 0, 0}},
    '{2, OpReset,  32'h0,          24'h0,      0, '{0, 0, 0, 0}},
    '{2, OpTarget, 32'hFFFF_0000,  24'h0,      0, '{0, 0, 0, 0}},
    '{2, OpTick,   32'h0,          24'd16,     0, '{0, 0, 0, 0}},
    '{2, OpTick,   32'h0,          24'd17,     0, '{0, 0, 0, 0}},
    '{2, OpTick,   32'h0,          24'h10_0000, 0, '{0, 0, 0, 0}},
    '{3, OpReset,  32'h8000_0000,  24'h0,      0, '{0, 0, 0, 0}},
    '{3, OpTarget, 32'h7FFF_FFFF,  24'h0,      0, '{0, 0, 0, 0}},
    '{3, OpTick,   32'h0,          24'hFFFFFF, 0, '{0, 0, 0, 0}},
    '{3, OpTick,   32'h0,          24'hFFFFFF, 0, '{0, 0, 0, 0}},
    '{3, OpTick,   32'h0,          24'h00_8000, 0, '{0, 0, 0, 0}}
  };

  initial begin
    int cur_set;
    int r;
    logic [1:0] op;
    logic [31:0] pos;
    plan_t none;
    none = '{default: '0};
    prof_mode = 0;
    rate_max = 0;
    accel_max = 0;
    jerk_max = 0;
    tol_cfg = 0;
    goal_pos = 0;
    cur_pos = 0;
    cur_rate = 0;
    cur_accel = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    cur_set = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].setting != cur_set) begin
        in_valid_i = 1'b0;
        cur_set = dir_rows[i].setting;
        configure(dir_set[cur_set][0], dir_set[cur_set][1], dir_set[cur_set][2],
                  dir_set[cur_set][3], dir_set[cur_set][4]);
      end
      send(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].dt, dir_rows[i].typed,
           dir_rows[i].want);
    end

    for (int ph = 0; ph < 12; ph++) begin
      in_valid_i = 1'b0;
      calm = (ph == 4);
      if (ph == 0) configure(ModeTrap, 32'h0008_0000, 32'h0010_0000, 0, 0);
      else if (ph == 1) configure(ModeScurve, 32'h0008_0000, 32'h0010_0000,
                                  32'h0040_0000, 0);
      else configure($urandom_range(ph == 11 ? 3 : 2, 3) == 3 ? $urandom_range(3)
                                                              : $urandom_range(1, 2),
                     pick_limit(), pick_limit(), pick_limit(),
                     $urandom_range(1) ? 0 : pick_limit());
      for (int k = 0; k < 80; k++) begin
        if (ph == 2 && k == 20) hold_cnt = 400;
        if (ph == 3 && k == 40) begin
          in_valid_i = 1'b0;
          wait (plan_q.size() == 0);
          @(negedge clk_i);
        end
        r = $urandom_range(99);
        pos = $urandom;
        pos = $signed(pos) >>> $urandom_range(0, 14);
        if (r < 6) begin
          op = $urandom_range(3);
          pos = $urandom;
        end else if (r < 10) begin
          op = OpReset;
        end else if (r < 20) begin
          op = OpTarget;
          if ($urandom_range(9) == 0) pos = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        end else begin
          op = OpTick;
        end
        send(op, pos, pick_dt(), 1'b0, none);
      end
    end
    in_valid_i = 1'b0;
    calm = 1'b0;

    wait (plan_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && plan_q.size() == 0) begin
      $display("position_motion_profile test passed");
    end else begin
      $display("position_motion_profile test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pmp_pkg.sv
sv/pmp_mul.sv
sv/pmp_iter.sv
sv/position_motion_profile.sv
sv/pmp_checker.sv
tb/tb.sv
